### rtl/core/mlpf_pkg.sv
// Package for the multi-level priority FIFO: shared constants, status codes
// and the per-beat control struct passed from the level table to the top level.
// No dependencies.
`default_nettype none

package mlpf_pkg;

    localparam int LEVELS_DEFAULT = 8;
    localparam int DEPTH_DEFAULT  = 16;

    localparam int DATA_W   = 8;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVELS_IN_USE_RESET = 4'd8;

    // Register indexes (word address = paddr[2]).
    localparam logic REG_LEVELS_IN_USE = 1'b0;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                wr_en;   // enqueue goes to the store
        logic                rd_en;   // dequeue reads the store
        logic [STATUS_W-1:0] status;
    } mlpf_op_t;

endpackage

`default_nettype wire

### rtl/core/mlpf_store.sv
// Entry store of the multi-level priority FIFO: one synchronous memory holding
// the rings of all levels, with one address shared by writes and registered reads.
// Depends on mlpf_pkg.
`default_nettype none

module mlpf_store #(
    parameter int ENTRIES = mlpf_pkg::LEVELS_DEFAULT * mlpf_pkg::DEPTH_DEFAULT,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               addr,
    input  wire logic [mlpf_pkg::DATA_W-1:0] wr_data,
    output logic      [mlpf_pkg::DATA_W-1:0] rd_data
);

    logic [mlpf_pkg::DATA_W-1:0] mem [ENTRIES];
    logic [mlpf_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/mlpf_level_table.sv
// Per-level ring bookkeeping: head, tail and occupancy of each level, the
// priority encoder for dequeues and the store address for the current beat.
// Depends on mlpf_pkg.
`default_nettype none

module mlpf_level_table #(
    parameter int LEVELS = mlpf_pkg::LEVELS_DEFAULT,
    parameter int DEPTH  = mlpf_pkg::DEPTH_DEFAULT,
    parameter int AW     = ((LEVELS * DEPTH) > 1) ? $clog2(LEVELS * DEPTH) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic                         operation,
    input  wire logic [mlpf_pkg::LEVEL_W-1:0] priority_level,
    input  wire logic [mlpf_pkg::LEVEL_W-1:0] levels_in_use,
    output mlpf_pkg::mlpf_op_t                op,
    output logic      [AW-1:0]                addr
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NW    = mlpf_pkg::LEVEL_W + 1;

    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];

    logic [NW-1:0]    n_active;
    logic [NW-1:0]    lvl_ext;
    logic [mlpf_pkg::LEVEL_W-1:0] lvl_m1;
    logic             enq_valid;
    logic [LVL_W-1:0] enq_q;
    logic             deq_found;
    logic [LVL_W-1:0] deq_q;
    logic [LVL_W-1:0] sel_q;
    logic [PTR_W-1:0] sel_ptr;
    logic [PTR_W-1:0] ptr_next;
    logic             sel_full;

    always_comb begin
        if ({1'b0, levels_in_use} > NW'(LEVELS)) begin
            n_active = NW'(LEVELS);
        end else begin
            n_active = {1'b0, levels_in_use};
        end
    end

    assign lvl_ext   = {1'b0, priority_level};
    assign enq_valid = (lvl_ext != '0) && (lvl_ext <= n_active);
    assign lvl_m1    = priority_level - 1'b1;
    assign enq_q     = lvl_m1[LVL_W-1:0];

    // Lowest-numbered active level that holds data wins.
    always_comb begin
        deq_found = 1'b0;
        deq_q     = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if ((NW'(i) < n_active) && (count_reg[i] != '0)) begin
                deq_found = 1'b1;
                deq_q     = LVL_W'(i);
            end
        end
    end

    assign sel_q    = (operation == mlpf_pkg::OP_DEQUEUE) ? deq_q : enq_q;
    assign sel_ptr  = (operation == mlpf_pkg::OP_DEQUEUE) ? head_reg[sel_q] : tail_reg[sel_q];
    assign ptr_next = (sel_ptr == PTR_W'(DEPTH - 1)) ? '0 : sel_ptr + 1'b1;
    assign sel_full = (count_reg[sel_q] == CNT_W'(DEPTH));
    assign addr     = AW'(sel_q) * AW'(DEPTH) + AW'(sel_ptr);

    always_comb begin
        op = '{wr_en: 1'b0, rd_en: 1'b0, status: mlpf_pkg::ST_OK};
        if (operation == mlpf_pkg::OP_DEQUEUE) begin
            if (deq_found) begin
                op.rd_en = accept;
            end else begin
                op.status = mlpf_pkg::ST_UNDERFLOW;
            end
        end else if (!enq_valid) begin
            op.status = mlpf_pkg::ST_INVALID;
        end else if (sel_full) begin
            op.status = mlpf_pkg::ST_FULL;
        end else begin
            op.wr_en = accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (op.wr_en) begin
            tail_reg[sel_q]  <= ptr_next;
            count_reg[sel_q] <= count_reg[sel_q] + 1'b1;
        end else if (op.rd_en) begin
            head_reg[sel_q]  <= ptr_next;
            count_reg[sel_q] <= count_reg[sel_q] - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/multi_level_priority_fifo.sv
// Multi-level priority FIFO: LEVELS rings of DEPTH bytes each, level 1 the
// highest priority. Each input beat is an enqueue (byte plus level) or a
// dequeue, and each gives exactly one result beat with a byte and a status
// (ok, invalid level, underflow, level full). One item is handled at a time.
// Enqueues, rejected enqueues and dequeues that find every active level empty
// produce their result in the cycle after acceptance; a dequeue that finds
// data goes through the registered read port of the entry store first. A new
// item is accepted while the previous result is being taken. levels_in_use
// (APB address 0, reset 8) limits the active levels; entries in levels above
// it are kept untouched. Depends on mlpf_pkg, mlpf_level_table, mlpf_store.
`default_nettype none

module multi_level_priority_fifo #(
    parameter int LEVELS = mlpf_pkg::LEVELS_DEFAULT,
    parameter int DEPTH  = mlpf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mlpf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mlpf_pkg::CFG_W-1:0]    pwdata,
    output logic      [mlpf_pkg::CFG_W-1:0]    prdata,
    output logic                               pready,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [mlpf_pkg::DATA_W-1:0]   s_item_data,
    input  wire logic [mlpf_pkg::LEVEL_W-1:0]  s_priority_level,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [mlpf_pkg::DATA_W-1:0]   m_out_data,
    output logic      [mlpf_pkg::STATUS_W-1:0] m_status
);

    localparam int AW = ((LEVELS * DEPTH) > 1) ? $clog2(LEVELS * DEPTH) : 1;

    logic [mlpf_pkg::LEVEL_W-1:0]  levels_in_use_reg;
    logic                          m_valid_reg;
    logic                          rd_pend_reg;
    logic [mlpf_pkg::DATA_W-1:0]   out_data_reg;
    logic [mlpf_pkg::STATUS_W-1:0] status_reg;

    logic                          accept;
    logic                          cfg_wr;
    mlpf_pkg::mlpf_op_t            op;
    logic [AW-1:0]                 addr;
    logic [mlpf_pkg::DATA_W-1:0]   rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_in_use_reg <= mlpf_pkg::LEVELS_IN_USE_RESET;
        end else if (cfg_wr && (paddr[2] == mlpf_pkg::REG_LEVELS_IN_USE)) begin
            levels_in_use_reg <= pwdata[mlpf_pkg::LEVEL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mlpf_pkg::REG_LEVELS_IN_USE) begin
            prdata = mlpf_pkg::CFG_W'(levels_in_use_reg);
        end
    end

    // The output register may be drained in the same cycle a new beat enters.
    assign s_ready = !rd_pend_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    mlpf_level_table #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_table (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .operation      (s_operation),
        .priority_level (s_priority_level),
        .levels_in_use  (levels_in_use_reg),
        .op             (op),
        .addr           (addr)
    );

    mlpf_store #(
        .ENTRIES (LEVELS * DEPTH),
        .AW      (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (op.wr_en),
        .rd_en   (op.rd_en),
        .addr    (addr),
        .wr_data (s_item_data),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= op.rd_en;
            if (rd_pend_reg || (accept && !op.rd_en)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            out_data_reg <= rd_data;
            status_reg   <= mlpf_pkg::ST_OK;
        end else if (accept && !op.rd_en) begin
            out_data_reg <= '0;
            status_reg   <= op.status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_data = out_data_reg;
    assign m_status   = status_reg;

endmodule

`default_nettype wire
